[sv/u2gb_pkg.sv]
// u2gb_pkg: shared types and constants for the UTF-16 to GB2312 converter.
// Used by the front classifier, the command queue and the back end.
package u2gb_pkg;

    localparam int CMD_W      = 1;
    localparam int INDEX_W    = 13;
    localparam int CODE_W     = 16;
    localparam int TLEN_W     = 14;
    localparam int BYTE_W     = 8;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CMD_W-1:0]  CMD_LOAD    = 1'b0;
    localparam logic [CMD_W-1:0]  CMD_CONVERT = 1'b1;

    localparam logic [CODE_W-1:0] CODE_NUL    = 16'h0000;
    localparam logic [CODE_W-1:0] CODE_NONCHAR = 16'hFFFF;
    localparam logic [CODE_W-1:0] CJK_FIRST   = 16'h4E00;
    localparam logic [BYTE_W-1:0] ASCII_LOW   = 8'h20;
    localparam logic [BYTE_W-1:0] ASCII_HIGH  = 8'h7E;
    localparam logic [BYTE_W-1:0] QMARK       = 8'h3F;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_TERM,
        OP_BYTE,
        OP_LOOKUP
    } op_kind_t;

    // One classified item: a table write, a string end, a single byte or a lookup.
    typedef struct packed {
        op_kind_t            kind;
        logic [INDEX_W-1:0]  index;
        logic [CODE_W-1:0]   key;
        logic [CODE_W-1:0]   data;
    } queue_entry_t;

endpackage

[sv/u2gb_front.sv]
// u2gb_front: accepts input transfers and classifies each into a queue entry.
// Depends on u2gb_pkg.
module u2gb_front #(
    parameter int TABLE_DEPTH = 8192
) (
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [u2gb_pkg::CMD_W-1:0]        s_command,
    input  logic [u2gb_pkg::INDEX_W-1:0]      s_entry_index,
    input  logic [u2gb_pkg::CODE_W-1:0]       s_entry_unicode,
    input  logic [u2gb_pkg::CODE_W-1:0]       s_entry_gb,
    input  logic [u2gb_pkg::CODE_W-1:0]       s_code_unit,
    input  logic                              q_ready,
    output logic                              q_push,
    output u2gb_pkg::queue_entry_t            q_wdata
);

    logic in_range;
    logic printable;

    assign s_ready   = q_ready;
    assign in_range  = 32'(s_entry_index) < 32'(TABLE_DEPTH);
    assign printable = (s_code_unit[7:0] >= u2gb_pkg::ASCII_LOW) &&
                       (s_code_unit[7:0] <= u2gb_pkg::ASCII_HIGH);

    // loads past the table end are dropped here
    assign q_push = s_valid && q_ready &&
                    !((s_command == u2gb_pkg::CMD_LOAD) && !in_range);

    always_comb begin
        q_wdata.index = s_entry_index;
        q_wdata.key   = s_entry_unicode;
        q_wdata.data  = s_entry_gb;
        q_wdata.kind  = u2gb_pkg::OP_LOAD;
        if (s_command == u2gb_pkg::CMD_CONVERT) begin
            q_wdata.key  = s_code_unit;
            q_wdata.data = {8'd0, u2gb_pkg::QMARK};
            if ((s_code_unit == u2gb_pkg::CODE_NUL) ||
                (s_code_unit == u2gb_pkg::CODE_NONCHAR)) begin
                q_wdata.kind = u2gb_pkg::OP_TERM;
            end else if (s_code_unit[15:8] == 8'd0) begin
                q_wdata.kind = u2gb_pkg::OP_BYTE;
                if (printable) begin
                    q_wdata.data = {8'd0, s_code_unit[7:0]};
                end
            end else if (s_code_unit >= u2gb_pkg::CJK_FIRST) begin
                q_wdata.kind = u2gb_pkg::OP_LOOKUP;
            end else begin
                q_wdata.kind = u2gb_pkg::OP_BYTE;
            end
        end
    end

endmodule

[sv/u2gb_queue.sv]
// u2gb_queue: short FIFO of classified entries between front and back end.
// Depends on u2gb_pkg.
module u2gb_queue (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         push,
    input  u2gb_pkg::queue_entry_t       wdata,
    output logic                         ready,
    output logic                         valid,
    output u2gb_pkg::queue_entry_t       rdata,
    input  logic                         pop
);

    localparam int QAW = $clog2(u2gb_pkg::QUEUE_DEPTH);
    localparam int CW  = $clog2(u2gb_pkg::QUEUE_DEPTH + 1);

    u2gb_pkg::queue_entry_t slots_reg [u2gb_pkg::QUEUE_DEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_push, do_pop;

    assign ready   = count_reg != CW'(u2gb_pkg::QUEUE_DEPTH);
    assign valid   = count_reg != '0;
    assign rdata   = slots_reg[rd_ptr_reg];
    assign do_push = push && ready;
    assign do_pop  = pop && valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + QAW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + QAW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + CW'(1);
        end else if (!do_push && do_pop) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

[sv/u2gb_back.sv]
// u2gb_back: table memory, binary search sequencer, character count and byte output.
// Depends on u2gb_pkg; fed by u2gb_queue.
module u2gb_back #(
    parameter int TABLE_DEPTH = 8192,
    parameter int MAX_CHARS   = 80
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [u2gb_pkg::TLEN_W-1:0]       cfg_wr_data,
    input  logic                              q_valid,
    input  u2gb_pkg::queue_entry_t            q_rdata,
    output logic                              q_pop,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [u2gb_pkg::BYTE_W-1:0]       m_out_byte,
    output logic                              m_is_terminator,
    output logic                              m_last
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int BW = AW + 1;
    localparam int NW = $clog2(MAX_CHARS + 1);
    localparam logic [BW-1:0] DEPTH_B = BW'(TABLE_DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_EMIT
    } state_t;

    state_t                          state_reg, state_next;
    logic [u2gb_pkg::TLEN_W-1:0]     table_len_reg, table_len_next;
    logic [6:0]                      char_count_reg, char_count_next;
    logic [u2gb_pkg::CODE_W-1:0]     key_reg, key_next;
    logic [BW-1:0]                   lo_reg, lo_next;
    logic [BW-1:0]                   hi_reg, hi_next;
    logic [AW-1:0]                   mid_reg, mid_next;
    logic [1:0]                      pend_cnt_reg, pend_cnt_next;
    logic                            pend_term_reg, pend_term_next;
    logic [7:0]                      hi_byte_reg, hi_byte_next;
    logic [7:0]                      lo_byte_reg, lo_byte_next;
    logic                            m_valid_reg, m_valid_next;
    logic [7:0]                      m_byte_reg, m_byte_next;
    logic                            m_term_reg, m_term_next;
    logic                            m_last_reg, m_last_next;

    logic [31:0]                     map_mem [TABLE_DEPTH];
    logic [31:0]                     rd_data_reg;
    logic                            mem_we, mem_re;
    logic [AW-1:0]                   wr_addr, rd_addr;
    logic [31:0]                     idx_ext;

    logic [BW-1:0]                   len_eff;
    logic                            out_free;
    logic                            char_done;
    logic [1:0]                      char_n;
    logic [7:0]                      char_hi, char_lo;
    logic [6:0]                      cnt_inc;
    logic [u2gb_pkg::CODE_W-1:0]     probe_key;
    logic [BW-1:0]                   nlo, nhi;
    logic                            emit_last;

    // midpoint of the half-open range [lo, hi), same as (lo + (hi-1)) / 2
    function automatic logic [AW-1:0] mid_of(input logic [BW-1:0] lo, input logic [BW-1:0] hi);
        logic [BW:0] s;
        s = {1'b0, lo} + {1'b0, hi} - (BW+1)'(1);
        return s[AW:1];
    endfunction

    assign len_eff = (32'(table_len_reg) > 32'(TABLE_DEPTH)) ? DEPTH_B : BW'(table_len_reg);
    assign out_free  = !m_valid_reg || m_ready;
    assign idx_ext   = 32'(q_rdata.index);
    assign wr_addr   = idx_ext[AW-1:0];
    assign probe_key = rd_data_reg[31:16];
    assign cnt_inc   = char_count_reg + 7'd1;

    assign m_valid         = m_valid_reg;
    assign m_out_byte      = m_byte_reg;
    assign m_is_terminator = m_term_reg;
    assign m_last          = m_last_reg;

    always_comb begin
        state_next      = state_reg;
        table_len_next  = table_len_reg;
        char_count_next = char_count_reg;
        key_next        = key_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        mid_next        = mid_reg;
        pend_cnt_next   = pend_cnt_reg;
        pend_term_next  = pend_term_reg;
        hi_byte_next    = hi_byte_reg;
        lo_byte_next    = lo_byte_reg;
        m_valid_next    = m_valid_reg;
        m_byte_next     = m_byte_reg;
        m_term_next     = m_term_reg;
        m_last_next     = m_last_reg;
        q_pop     = 1'b0;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        rd_addr   = '0;
        char_done = 1'b0;
        char_n    = 2'd0;
        char_hi   = 8'd0;
        char_lo   = 8'd0;
        nlo       = lo_reg;
        nhi       = hi_reg;
        emit_last = 1'b0;

        if (cfg_wr_en) begin
            table_len_next = cfg_wr_data;
        end
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop = 1'b1;
                    unique case (q_rdata.kind)
                        u2gb_pkg::OP_LOAD: begin
                            mem_we = 1'b1;
                        end
                        u2gb_pkg::OP_TERM: begin
                            pend_cnt_next   = 2'd0;
                            pend_term_next  = 1'b1;
                            char_count_next = 7'd0;
                            state_next      = ST_EMIT;
                        end
                        u2gb_pkg::OP_BYTE: begin
                            char_done = 1'b1;
                            char_n    = 2'd1;
                            char_lo   = q_rdata.data[7:0];
                        end
                        u2gb_pkg::OP_LOOKUP: begin
                            key_next = q_rdata.key;
                            lo_next  = '0;
                            hi_next  = len_eff;
                            if (len_eff != '0) begin
                                mem_re     = 1'b1;
                                rd_addr    = mid_of('0, len_eff);
                                mid_next   = rd_addr;
                                state_next = ST_PROBE;
                            end else begin
                                char_done = 1'b1;
                                char_n    = 2'd2;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_PROBE: begin
                if (probe_key == key_reg) begin
                    char_done = 1'b1;
                    char_n    = 2'd2;
                    char_hi   = rd_data_reg[15:8];
                    char_lo   = rd_data_reg[7:0];
                end else begin
                    if (probe_key > key_reg) begin
                        nhi = BW'(mid_reg);
                    end else begin
                        nlo = BW'(mid_reg) + BW'(1);
                    end
                    lo_next = nlo;
                    hi_next = nhi;
                    if (nlo < nhi) begin
                        mem_re   = 1'b1;
                        rd_addr  = mid_of(nlo, nhi);
                        mid_next = rd_addr;
                    end else begin
                        // miss: two zero bytes
                        char_done = 1'b1;
                        char_n    = 2'd2;
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (pend_cnt_reg != 2'd0) begin
                        m_byte_next   = (pend_cnt_reg == 2'd2) ? hi_byte_reg : lo_byte_reg;
                        m_term_next   = 1'b0;
                        emit_last     = (pend_cnt_reg == 2'd1) && !pend_term_reg;
                        pend_cnt_next = pend_cnt_reg - 2'd1;
                    end else begin
                        m_byte_next    = 8'd0;
                        m_term_next    = 1'b1;
                        emit_last      = 1'b1;
                        pend_term_next = 1'b0;
                    end
                    m_last_next = emit_last;
                    if (emit_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // a finished character: queue its bytes, count it, maybe add a terminator
        if (char_done) begin
            pend_cnt_next = char_n;
            hi_byte_next  = char_hi;
            lo_byte_next  = char_lo;
            if (NW'(cnt_inc) >= NW'(MAX_CHARS)) begin
                char_count_next = 7'd0;
                pend_term_next  = 1'b1;
            end else begin
                char_count_next = cnt_inc;
                pend_term_next  = 1'b0;
            end
            state_next = ST_EMIT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            table_len_reg  <= '0;
            char_count_reg <= '0;
            pend_cnt_reg   <= '0;
            pend_term_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            table_len_reg  <= table_len_next;
            char_count_reg <= char_count_next;
            pend_cnt_reg   <= pend_cnt_next;
            pend_term_reg  <= pend_term_next;
            m_valid_reg    <= m_valid_next;
        end
        key_reg     <= key_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        mid_reg     <= mid_next;
        hi_byte_reg <= hi_byte_next;
        lo_byte_reg <= lo_byte_next;
        m_byte_reg  <= m_byte_next;
        m_term_reg  <= m_term_next;
        m_last_reg  <= m_last_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            map_mem[wr_addr] <= {q_rdata.key, q_rdata.data};
        end
        if (mem_re) begin
            rd_data_reg <= map_mem[rd_addr];
        end
    end

endmodule

[sv/utf16_to_gb2312_stream_converter.sv]
// Throughput: the back end takes one queued item at a time and finishes it
// before the next; an ASCII or '?' character needs no lookup, a table lookup
// makes P <= ceil(log2(len+1)) probes, one per cycle on the single table
// read port (14 at 8192 entries). Output bytes of a result follow one per
// cycle while m_ready is high.
// Reset (aresetn low, synchronous) empties the queue and output and clears
// table_length and the character count; table contents stay undefined.
module utf16_to_gb2312_stream_converter #(
    parameter int TABLE_DEPTH = 8192,
    parameter int MAX_CHARS   = 80
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [u2gb_pkg::TLEN_W-1:0]       cfg_wr_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [u2gb_pkg::CMD_W-1:0]        s_command,
    input  logic [u2gb_pkg::INDEX_W-1:0]      s_entry_index,
    input  logic [u2gb_pkg::CODE_W-1:0]       s_entry_unicode,
    input  logic [u2gb_pkg::CODE_W-1:0]       s_entry_gb,
    input  logic [u2gb_pkg::CODE_W-1:0]       s_code_unit,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [u2gb_pkg::BYTE_W-1:0]       m_out_byte,
    output logic                              m_is_terminator,
    output logic                              m_last
);

    logic                       q_ready;
    logic                       q_push;
    u2gb_pkg::queue_entry_t     q_wdata;
    logic                       q_valid;
    u2gb_pkg::queue_entry_t     q_rdata;
    logic                       q_pop;

    u2gb_front #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_front (
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_entry_index   (s_entry_index),
        .s_entry_unicode (s_entry_unicode),
        .s_entry_gb      (s_entry_gb),
        .s_code_unit     (s_code_unit),
        .q_ready         (q_ready),
        .q_push          (q_push),
        .q_wdata         (q_wdata)
    );

    u2gb_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .ready   (q_ready),
        .valid   (q_valid),
        .rdata   (q_rdata),
        .pop     (q_pop)
    );

    u2gb_back #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .MAX_CHARS  (MAX_CHARS)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .q_valid         (q_valid),
        .q_rdata         (q_rdata),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_byte      (m_out_byte),
        .m_is_terminator (m_is_terminator),
        .m_last          (m_last)
    );

endmodule

[sv/u2gb_checker.sv]
// u2gb_checker: port-level assertions for the converter, bound to the top level.
// Depends on utf16_to_gb2312_stream_converter port names.
module u2gb_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_out_byte,
    input  logic       m_is_terminator,
    input  logic       m_last
);

    // after reset nothing is pending and the input side is open
    a_reset_clean: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("output valid or input stalled right after reset");

    // a stalled output transfer holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) &&
                                $stable(m_is_terminator) && $stable(m_last))
        else $error("output transfer changed while stalled");

    // a terminator is a zero byte and closes the item's results
    a_term_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_terminator |-> m_out_byte == 8'd0 && m_last)
        else $error("terminator not zero or not last");

    // the bytes of one item follow each other without a gap
    a_item_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=> m_valid)
        else $error("gap inside the bytes of one item");

endmodule

bind utf16_to_gb2312_stream_converter u2gb_checker u_u2gb_checker (.*);
